@@ rtl/core/ibf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibf_pkg: shared types and constants of the information frame framer
// Line codes, register indexes, the framing command and the emit sequence.
// ----------------------------------------------------------------------------
package ibf_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_MASK  = 8'h20;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ0 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ1 = 2'd2;

  localparam logic [7:0] ADDRESS_RST   = 8'd3;
  localparam logic [7:0] CTRL_SEQ0_RST = 8'd0;
  localparam logic [7:0] CTRL_SEQ1_RST = 8'd64;

  // command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one classified payload transaction
  typedef struct packed {
    logic       hdr;       // first byte of a frame: send header first
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] data;
    logic       data_esc;
    logic       last;
    logic [7:0] chk;       // trailing check, valid when last
    logic       chk_esc;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OPEN,
    ST_ADDR,
    ST_CTRL,
    ST_HCHK,
    ST_DATA,
    ST_DATA2,
    ST_CHK,
    ST_CHK2,
    ST_CLOSE
  } step_t;

endpackage
`default_nettype wire

@@ rtl/core/ibf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibf_front: input stage of the framer
// Accepts payload bytes, tracks the open frame and running xor, and classifies
// each byte into a command for the queue.
// ----------------------------------------------------------------------------
module ibf_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [7:0]       in_data_byte,
  input  wire              in_last_byte,
  input  wire              in_sequence_bit,
  input  wire  [7:0]       address,
  input  wire  [7:0]       ctrl_seq0,
  input  wire  [7:0]       ctrl_seq1,
  input  wire              q_full,
  output logic             push,
  output ibf_pkg::cmd_t    push_cmd
);

  logic       inside_frame_r, inside_frame_nxt;
  logic [7:0] payload_xor_r, payload_xor_nxt;
  logic [7:0] xor_sum;
  logic [7:0] ctrl_sel;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    ctrl_sel = in_sequence_bit ? ctrl_seq1 : ctrl_seq0;
    // a new frame starts its check from zero
    xor_sum  = (inside_frame_r ? payload_xor_r : 8'h00) ^ in_data_byte;

    push_cmd.hdr      = !inside_frame_r;
    push_cmd.addr     = address;
    push_cmd.ctrl     = ctrl_sel;
    push_cmd.data     = in_data_byte;
    push_cmd.data_esc = (in_data_byte == ibf_pkg::FLAG_BYTE) ||
                        (in_data_byte == ibf_pkg::ESC_BYTE);
    push_cmd.last     = in_last_byte;
    push_cmd.chk      = xor_sum;
    push_cmd.chk_esc  = (xor_sum == ibf_pkg::FLAG_BYTE) ||
                        (xor_sum == ibf_pkg::ESC_BYTE);

    inside_frame_nxt = inside_frame_r;
    payload_xor_nxt  = payload_xor_r;
    if (push) begin
      inside_frame_nxt = !in_last_byte;
      payload_xor_nxt  = in_last_byte ? 8'h00 : xor_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_frame_r <= 1'b0;
      payload_xor_r  <= 8'h00;
    end else begin
      inside_frame_r <= inside_frame_nxt;
      payload_xor_r  <= payload_xor_nxt;
    end
  end

  a_xor_clear_outside: assert property (@(posedge clk) disable iff (!rst_n)
    !inside_frame_r |-> payload_xor_r == 8'h00)
    else $error("running xor not cleared outside a frame");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_last_byte |=> !inside_frame_r)
    else $error("frame still open after last byte");

  a_hdr_on_open: assert property (@(posedge clk) disable iff (!rst_n)
    push && !in_last_byte |=> inside_frame_r)
    else $error("frame not open after non-final byte");

endmodule
`default_nettype wire

@@ rtl/core/ibf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibf_queue: short command queue
// Register-based fifo that decouples the front and back stalls.
// ----------------------------------------------------------------------------
module ibf_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  ibf_pkg::cmd_t    push_cmd,
  output logic             full,
  input  wire              pop,
  output logic             head_valid,
  output ibf_pkg::cmd_t    head_cmd
);

  ibf_pkg::cmd_t entry_r [ibf_pkg::QDEPTH];

  logic [ibf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ibf_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ibf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [ibf_pkg::QPTR_W-1:0] PTR_LAST = ibf_pkg::QPTR_W'(ibf_pkg::QDEPTH - 1);
  localparam logic [ibf_pkg::QCNT_W-1:0] CNT_FULL = ibf_pkg::QCNT_W'(ibf_pkg::QDEPTH);

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ rtl/core/ibf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibf_back: line byte sequencer
// Walks one command through header, stuffed data, stuffed check and closing
// flag as needed into a registered output, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module ibf_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              head_valid,
  input  ibf_pkg::cmd_t    head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [7:0]       out_out_byte,
  output logic             out_frame_end,
  output logic             out_run_last
);

  ibf_pkg::step_t step_r, step_nxt, step_adv;
  ibf_pkg::cmd_t  cur_r, cur_nxt;
  logic           cur_valid_r, cur_valid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     byte_r, byte_nxt, byte_c;
  logic           fend_r, fend_nxt, fend_c;
  logic           rlast_r, rlast_nxt, done_c;
  logic           emit;

  assign out_valid     = out_valid_r;
  assign out_out_byte  = byte_r;
  assign out_frame_end = fend_r;
  assign out_run_last  = rlast_r;

  always_comb begin
    byte_c   = ibf_pkg::FLAG_BYTE;
    fend_c   = 1'b0;
    done_c   = 1'b0;
    step_adv = step_r;
    unique case (step_r)
      ibf_pkg::ST_OPEN: begin
        byte_c   = ibf_pkg::FLAG_BYTE;
        step_adv = ibf_pkg::ST_ADDR;
      end
      ibf_pkg::ST_ADDR: begin
        byte_c   = cur_r.addr;
        step_adv = ibf_pkg::ST_CTRL;
      end
      ibf_pkg::ST_CTRL: begin
        byte_c   = cur_r.ctrl;
        step_adv = ibf_pkg::ST_HCHK;
      end
      ibf_pkg::ST_HCHK: begin
        byte_c   = cur_r.addr ^ cur_r.ctrl;
        step_adv = ibf_pkg::ST_DATA;
      end
      ibf_pkg::ST_DATA: begin
        byte_c   = cur_r.data_esc ? ibf_pkg::ESC_BYTE : cur_r.data;
        step_adv = cur_r.data_esc ? ibf_pkg::ST_DATA2 : ibf_pkg::ST_CHK;
        done_c   = !cur_r.data_esc && !cur_r.last;
      end
      ibf_pkg::ST_DATA2: begin
        byte_c   = cur_r.data ^ ibf_pkg::ESC_MASK;
        step_adv = ibf_pkg::ST_CHK;
        done_c   = !cur_r.last;
      end
      ibf_pkg::ST_CHK: begin
        byte_c   = cur_r.chk_esc ? ibf_pkg::ESC_BYTE : cur_r.chk;
        step_adv = cur_r.chk_esc ? ibf_pkg::ST_CHK2 : ibf_pkg::ST_CLOSE;
      end
      ibf_pkg::ST_CHK2: begin
        byte_c   = cur_r.chk ^ ibf_pkg::ESC_MASK;
        step_adv = ibf_pkg::ST_CLOSE;
      end
      ibf_pkg::ST_CLOSE: begin
        byte_c   = ibf_pkg::FLAG_BYTE;
        fend_c   = 1'b1;
        done_c   = 1'b1;
      end
      default: begin
        byte_c   = ibf_pkg::FLAG_BYTE;
        done_c   = 1'b1;
      end
    endcase

    // output slot free or being drained this cycle
    emit = cur_valid_r && (!out_valid_r || out_ready);
    pop  = head_valid && (!cur_valid_r || (emit && done_c));

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    priority if (pop) begin
      cur_nxt       = head_cmd;
      cur_valid_nxt = 1'b1;
      step_nxt      = head_cmd.hdr ? ibf_pkg::ST_OPEN : ibf_pkg::ST_DATA;
    end else if (emit && done_c) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      step_nxt      = step_adv;
    end else begin
      step_nxt      = step_r;
    end

    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    fend_nxt      = fend_r;
    rlast_nxt     = rlast_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = byte_c;
      fend_nxt      = fend_c;
      rlast_nxt     = done_c;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ibf_pkg::ST_OPEN;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    byte_r  <= byte_nxt;
    fend_r  <= fend_nxt;
    rlast_r <= rlast_nxt;
  end

  a_close_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fend_r |-> rlast_r && byte_r == ibf_pkg::FLAG_BYTE)
    else $error("closing byte malformed");

  a_esc_second_half: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && step_r == ibf_pkg::ST_DATA2 |-> cur_r.data_esc)
    else $error("escape tail without escaped data");

  a_chk_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && (step_r == ibf_pkg::ST_CHK || step_r == ibf_pkg::ST_CHK2 ||
                    step_r == ibf_pkg::ST_CLOSE) |-> cur_r.last)
    else $error("trailer sent for non-final byte");

endmodule
`default_nettype wire

@@ rtl/core/info_frame_byte_stuffing_framer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// info_frame_byte_stuffing_framer: information frame framer with stuffing
// Wraps payload bytes in flag, address, control and header check, stuffs
// payload and trailing xor check, and closes each frame with a flag.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | in_data_byte, in_last_byte, in_sequence_bit
//  out      | out_valid / out_ready | out_out_byte, out_frame_end, out_run_last
//  cfg      | cfg_wr_en             | cfg_index, cfg_data
//
// one line byte per cycle out of the back sequencer while out_ready and the queue allow: a
// payload byte yields 1 to 9 line bytes (4 more on the first of a frame, 1 more for each
// escape, 2 to 3 more on the last), so one in the middle of a frame when nothing is escaped
// a two-entry command queue lets the front keep accepting while the back works
// reset is synchronous, active low; no clearing pass
// out_ready low holds the output register and, once the queue fills, in_ready
// ----------------------------------------------------------------------------
module info_frame_byte_stuffing_framer (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [7:0]                      in_data_byte,
  input  wire                             in_last_byte,
  input  wire                             in_sequence_bit,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [7:0]                      out_out_byte,
  output logic                            out_frame_end,
  output logic                            out_run_last,
  input  wire                             cfg_wr_en,
  input  wire  [ibf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [7:0]                      cfg_data
);

  logic [7:0]    address_r, ctrl_seq0_r, ctrl_seq1_r;
  logic          q_full, push, pop, head_valid;
  ibf_pkg::cmd_t push_cmd, head_cmd;

  // register file; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r   <= ibf_pkg::ADDRESS_RST;
      ctrl_seq0_r <= ibf_pkg::CTRL_SEQ0_RST;
      ctrl_seq1_r <= ibf_pkg::CTRL_SEQ1_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ibf_pkg::REG_ADDRESS:   address_r   <= cfg_data;
        ibf_pkg::REG_CTRL_SEQ0: ctrl_seq0_r <= cfg_data;
        ibf_pkg::REG_CTRL_SEQ1: ctrl_seq1_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ibf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .in_sequence_bit (in_sequence_bit),
    .address         (address_r),
    .ctrl_seq0       (ctrl_seq0_r),
    .ctrl_seq1       (ctrl_seq1_r),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  ibf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ibf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_byte  (out_out_byte),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

endmodule
`default_nettype wire

@@ sim/tb_info_frame_byte_stuffing_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_info_frame_byte_stuffing_framer: self-checking bench for the frame framer
// Drives payload bytes through a directed table and then random frames under
// several register settings, predicts the stuffed line stream of each byte and
// checks every output transaction field by field, with random idling both
// sides and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_info_frame_byte_stuffing_framer;

  localparam int unsigned CFG_IDX_W = ibf_pkg::CFG_IDX_W;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS   = ibf_pkg::REG_ADDRESS;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ0 = ibf_pkg::REG_CTRL_SEQ0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ1 = ibf_pkg::REG_CTRL_SEQ1;
  localparam logic [7:0] FLAG_BYTE     = ibf_pkg::FLAG_BYTE;
  localparam logic [7:0] ESC_BYTE      = ibf_pkg::ESC_BYTE;
  localparam logic [7:0] ESC_MASK      = ibf_pkg::ESC_MASK;
  localparam logic [7:0] ADDRESS_RST   = ibf_pkg::ADDRESS_RST;
  localparam logic [7:0] CTRL_SEQ0_RST = ibf_pkg::CTRL_SEQ0_RST;
  localparam logic [7:0] CTRL_SEQ1_RST = ibf_pkg::CTRL_SEQ1_RST;

  localparam int unsigned PAYLOAD_TOTAL = 350;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {
    ROW_PAYLOAD,
    ROW_REG_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [7:0]            value;
    logic                  last;
    logic                  seq;
    logic [3:0]            n_typed;
    logic [71:0]           typed;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fend;
    logic       rlast;
  } line_beat_t;

  localparam int unsigned DIR_N = 29;
  localparam logic [71:0] UNTYPED = 72'h0;

  // typed bytes are listed first byte leftmost
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    // reset registers: address 03, controls 00 / 40
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h00, 1'b1, 1'b0, 4'd7, 72'h7E_03_00_03_00_00_7E_00_00},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'hFF, 1'b1, 1'b1, 4'd7, 72'h7E_03_40_43_FF_FF_7E_00_00},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h7E, 1'b1, 1'b0, 4'd9, 72'h7E_03_00_03_7D_5E_7D_5E_7E},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h7D, 1'b1, 1'b1, 4'd9, 72'h7E_03_40_43_7D_5D_7D_5D_7E},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h01, 1'b0, 1'b1, 4'd5, 72'h7E_03_40_43_01_00_00_00_00},
    // sequence bit flips inside the frame and must be ignored
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h7E, 1'b0, 1'b0, 4'd2, 72'h7D_5E_00_00_00_00_00_00_00},
    // running check lands on the flag code
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h01, 1'b1, 1'b0, 4'd4, 72'h01_7D_5E_7E_00_00_00_00_00},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h20, 1'b0, 1'b1, 4'd5, 72'h7E_03_40_43_20_00_00_00_00},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h5D, 1'b1, 1'b0, 4'd4, 72'h5D_7D_5D_7E_00_00_00_00_00},
    // header bytes equal to flag / escape go out unstuffed
    '{ROW_REG_WRITE, REG_ADDRESS,   8'h7E, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_REG_WRITE, REG_CTRL_SEQ0, 8'h7D, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_REG_WRITE, REG_CTRL_SEQ1, 8'hFF, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_REG_WRITE, REG_SPARE,     8'hAA, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h80, 1'b0, 1'b0, 4'd5, 72'h7E_7E_7D_03_80_00_00_00_00},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h00, 1'b1, 1'b1, 4'd3, 72'h00_80_7E_00_00_00_00_00_00},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h55, 1'b1, 1'b1, 4'd7, 72'h7E_7E_FF_81_55_55_7E_00_00},
    '{ROW_REG_WRITE, REG_ADDRESS,   8'h00, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_REG_WRITE, REG_CTRL_SEQ0, 8'hFF, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_REG_WRITE, REG_CTRL_SEQ1, 8'h00, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_REG_WRITE, REG_SPARE,     8'h55, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'hAA, 1'b1, 1'b0, 4'd7, 72'h7E_00_FF_FF_AA_AA_7E_00_00},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h7D, 1'b0, 1'b1, 4'd6, 72'h7E_00_00_00_7D_5D_00_00_00},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h7D, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h7E, 1'b0, 1'b1, 4'd0, UNTYPED},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h03, 1'b1, 1'b0, 4'd4, 72'h03_7D_5D_7E_00_00_00_00_00},
    '{ROW_REG_WRITE, REG_ADDRESS,   8'hFF, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_REG_WRITE, REG_CTRL_SEQ0, 8'h00, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_REG_WRITE, REG_CTRL_SEQ1, 8'h7E, 1'b0, 1'b0, 4'd0, UNTYPED},
    '{ROW_PAYLOAD, REG_ADDRESS, 8'h7E, 1'b1, 1'b1, 4'd9, 72'h7E_FF_7E_81_7D_5E_7D_5E_7E}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 in_last_byte = 1'b0;
  logic                 in_sequence_bit = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_out_byte;
  logic                 out_frame_end;
  logic                 out_run_last;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;

  // framer model state
  logic [7:0] addr_reg = ADDRESS_RST;
  logic [7:0] ctrl0_reg = CTRL_SEQ0_RST;
  logic [7:0] ctrl1_reg = CTRL_SEQ1_RST;
  logic       frame_open = 1'b0;
  logic [7:0] running_xor = 8'h00;

  line_beat_t line_bytes_due[$];
  line_beat_t beats_of_byte [0:8];
  int         n_beats;

  int  mismatches = 0;
  int  bytes_seen = 0;
  int  hold_left = 0;
  bit  big_hold_done = 1'b0;
  bit  tx_burst = 1'b0;
  bit  rx_steady = 1'b0;

  info_frame_byte_stuffing_framer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .in_sequence_bit (in_sequence_bit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_frame_end   (out_frame_end),
    .out_run_last    (out_run_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void put_beat(input logic [7:0] b, input logic fend);
    beats_of_byte[n_beats] = '{b: b, fend: fend, rlast: 1'b0};
    n_beats++;
  endfunction

  function automatic void put_escaped(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      put_beat(ESC_BYTE, 1'b0);
      put_beat(b ^ ESC_MASK, 1'b0);
    end else begin
      put_beat(b, 1'b0);
    end
  endfunction

  // line bytes caused by one payload byte, state advanced as the framer does
  function automatic void frame_line_bytes(input logic [7:0] d, input logic lst,
                                           input logic sq);
    logic [7:0] ctrl;
    n_beats = 0;
    if (!frame_open) begin
      ctrl = sq ? ctrl1_reg : ctrl0_reg;
      put_beat(FLAG_BYTE, 1'b0);
      put_beat(addr_reg, 1'b0);
      put_beat(ctrl, 1'b0);
      put_beat(addr_reg ^ ctrl, 1'b0);
      frame_open = 1'b1;
      running_xor = 8'h00;
    end
    put_escaped(d);
    running_xor = running_xor ^ d;
    if (lst) begin
      put_escaped(running_xor);
      put_beat(FLAG_BYTE, 1'b1);
      frame_open = 1'b0;
      running_xor = 8'h00;
    end
    beats_of_byte[n_beats-1].rlast = 1'b1;
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_data();
    logic [7:0] specials [8] = '{8'h00, 8'hFF, FLAG_BYTE, ESC_BYTE, 8'h20, 8'h5E,
                                 8'h5D, 8'h80};
    if ($urandom_range(0, 99) < 30) return specials[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return FLAG_BYTE;
      3: return ESC_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 10);
    return $urandom_range(11, 24);
  endfunction

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_ADDRESS:   addr_reg = v;
      REG_CTRL_SEQ0: ctrl0_reg = v;
      REG_CTRL_SEQ1: ctrl1_reg = v;
      default: ;
    endcase
  endtask

  // one payload transaction; typed bytes, when given, replace the prediction
  task automatic offer_payload(input logic [7:0] d, input logic lst, input logic sq,
                               input logic [3:0] n_typed = 4'd0,
                               input logic [71:0] typed = '0);
    int gap;
    gap = pick_gap(tx_burst);
    cfg_wr_en <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= lst;
    in_sequence_bit <= sq;
    do @(posedge clk); while (!in_ready);
    frame_line_bytes(d, lst, sq);
    if (n_typed != 0) begin
      for (int i = 0; i < n_typed; i++) begin
        line_bytes_due.push_back('{b: typed[71-8*i -: 8],
                                   fend: lst && (i == n_typed - 1),
                                   rlast: (i == n_typed - 1)});
      end
    end else begin
      for (int i = 0; i < n_beats; i++) line_bytes_due.push_back(beats_of_byte[i]);
    end
  endtask

  task automatic drain_line();
    in_valid <= 1'b0;
    while (line_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // output side: checks each transaction and chooses out_ready
  always @(posedge clk) begin
    line_beat_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (line_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected line byte %02h end %b run_last %b", $realtime,
                     out_out_byte, out_frame_end, out_run_last);
        end else begin
          want = line_bytes_due.pop_front();
          if (want.b !== out_out_byte || want.fend !== out_frame_end ||
              want.rlast !== out_run_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: line byte mismatch: exp %02h end %b run_last %b, got %02h %b %b",
                       $realtime, want.b, want.fend, want.rlast,
                       out_out_byte, out_frame_end, out_run_last);
          end
        end
      end
      if ($urandom_range(0, 149) == 0) rx_steady = ~rx_steady;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!big_hold_done && bytes_seen >= 300) begin
        // long hold-off so the command queue fills and in_ready drops
        big_hold_done = 1'b1;
        hold_left = 150;
        out_ready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 99) < 3) begin
        hold_left = $urandom_range(10, 30);
        out_ready <= 1'b0;
      end else begin
        out_ready <= rx_steady || ($urandom_range(0, 99) < 70);
      end
    end
  end

  initial begin
    int sent;
    int phase_len;
    int flen;
    int done_in_phase;
    stim_row_t row;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      row = DIR_ROWS[r];
      if (row.kind == ROW_REG_WRITE) begin
        if (r == 0 || DIR_ROWS[r-1].kind != ROW_REG_WRITE) drain_line();
        reg_write(row.idx, row.value);
      end else begin
        offer_payload(row.value, row.last, row.seq, row.n_typed, row.typed);
        sent++;
      end
    end

    while (sent < PAYLOAD_TOTAL) begin
      drain_line();
      reg_write(REG_ADDRESS, pick_reg_value());
      reg_write(REG_CTRL_SEQ0, pick_reg_value());
      reg_write(REG_CTRL_SEQ1, pick_reg_value());
      if ($urandom_range(0, 3) == 0) reg_write(REG_SPARE, 8'($urandom));
      tx_burst = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(25, 55);
      done_in_phase = 0;
      while (done_in_phase < phase_len && sent < PAYLOAD_TOTAL) begin
        flen = pick_frame_len();
        for (int j = 0; j < flen; j++)
          offer_payload(pick_data(), j == flen - 1, 1'($urandom));
        done_in_phase += flen;
        sent += flen;
      end
    end

    drain_line();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && line_bytes_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
